// ----- rtl/ehpd_pkg.sv -----
`timescale 1ns / 1ps

package ehpd_pkg;

  localparam int SampleBits    = 14;
  localparam int AlphaFracBits = 15;
  localparam int AlphaW        = 16;
  localparam int CfgDataW      = 16;
  localparam int CfgIndexW     = 2;
  localparam int AvgW          = SampleBits + AlphaFracBits;
  localparam int ProdW         = AvgW + AlphaW + 2;
  localparam int SumW          = AvgW + 2;
  localparam int InDataW       = ((SampleBits + 7) / 8) * 8;
  localparam int OutDataW      = ((SampleBits + 1 + 7) / 8) * 8;

  localparam int OneFix     = 1 << AlphaFracBits;
  localparam int AlphaMin   = (OneFix + 99) / 100;
  localparam int AlphaMax   = OneFix;
  localparam int StartLimit = OneFix / 100;
  localparam int AlphaReset = 3277;

  localparam logic [SampleBits-1:0] SampleMax = {SampleBits{1'b1}};
  localparam logic [AvgW-1:0] AvgMax   = {SampleMax, {AlphaFracBits{1'b0}}};
  localparam logic [AvgW-1:0] HalfFix  = AvgW'(1) << (AlphaFracBits - 1);
  localparam logic [AvgW-1:0] StartLim = AvgW'(StartLimit);

  typedef enum logic [CfgIndexW-1:0] {
    RegAlpha  = 2'd0,
    RegThrOn  = 2'd1,
    RegThrOff = 2'd2
  } cfg_reg_e;

endpackage

// ----- rtl/ema_hysteresis_presence_detector.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata[13:0] sample
// m_axis    out        tdata[13:0] smoothed, tdata[14] occupied
// cfg       in         cfg_index_i register, cfg_data_i value
//
// One sample per cycle sustained while m_axis is ready; a sample passes from s_axis to m_axis
// through the input register, then the multiply-add, rounding and threshold compare into
// the result register, where the average and seat state are also updated.
// Reset clears the average, the seat decision and the registers to defaults.
// A stall on m_axis holds the result; one more sample waits in the input stage.
module ema_hysteresis_presence_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ehpd_pkg::InDataW-1:0]        s_axis_tdata,  // [13:0] sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ehpd_pkg::OutDataW-1:0]       m_axis_tdata,  // [13:0] smoothed, [14] occupied
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ehpd_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [ehpd_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int Sb = ehpd_pkg::SampleBits;
  localparam int Fb = ehpd_pkg::AlphaFracBits;
  localparam int Aw = ehpd_pkg::AvgW;
  localparam int Pw = ehpd_pkg::ProdW;
  localparam int Sw = ehpd_pkg::SumW;

  // configuration registers
  logic [ehpd_pkg::AlphaW-1:0] alpha_q;
  logic [Sb-1:0]               thr_on_q, thr_off_q;

  // pipeline registers
  logic          s1_valid_q;
  logic [Sb-1:0] s1_sample_q;
  logic          out_valid_q;
  logic [Sb-1:0] out_smoothed_q;
  logic          out_occ_q;

  // filter state
  logic [Aw-1:0] avg_q, avg_d;
  logic          seat_q, seat_d;

  logic s_fire, s1_fire, out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ehpd_pkg::AlphaW'(ehpd_pkg::AlphaReset);
      thr_on_q  <= ehpd_pkg::SampleMax;
      thr_off_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (ehpd_pkg::cfg_reg_e'(cfg_index_i))
        ehpd_pkg::RegAlpha: begin
          if (cfg_data_i < ehpd_pkg::CfgDataW'(ehpd_pkg::AlphaMin)) begin
            alpha_q <= ehpd_pkg::AlphaW'(ehpd_pkg::AlphaMin);
          end else if (cfg_data_i > ehpd_pkg::CfgDataW'(ehpd_pkg::AlphaMax)) begin
            alpha_q <= ehpd_pkg::AlphaW'(ehpd_pkg::AlphaMax);
          end else begin
            alpha_q <= ehpd_pkg::AlphaW'(cfg_data_i);
          end
        end
        ehpd_pkg::RegThrOn:  thr_on_q  <= cfg_data_i[Sb-1:0];
        ehpd_pkg::RegThrOff: thr_off_q <= cfg_data_i[Sb-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_load      = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_load;
  assign s_axis_tready = !s1_valid_q || out_load;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // datapath
  logic [Aw-1:0]        target;
  logic signed [Aw:0]   diff;
  logic signed [Pw-1:0] prod;
  logic signed [Pw-1:0] rnd;
  logic signed [Sw-1:0] inc;
  logic signed [Sw-1:0] sum;
  logic [Aw:0]          avg_rnd;
  logic [Sb:0]          f_wide;
  logic [Sb-1:0]        smoothed;

  always_comb begin
    target = {s1_sample_q, {Fb{1'b0}}};
    diff   = $signed({1'b0, target}) - $signed({1'b0, avg_q});
    prod   = $signed({1'b0, alpha_q}) * diff;
    rnd    = prod + $signed(Pw'(ehpd_pkg::HalfFix));
    // arithmetic shift gives floor, so the half bias rounds exact halves up
    inc    = Sw'(rnd >>> Fb);
    sum    = $signed({2'b00, avg_q}) + inc;

    if (avg_q <= ehpd_pkg::StartLim) begin
      avg_d = target;
    end else if (sum < 0) begin
      avg_d = '0;
    end else if (sum > $signed({2'b00, ehpd_pkg::AvgMax})) begin
      avg_d = ehpd_pkg::AvgMax;
    end else begin
      avg_d = sum[Aw-1:0];
    end

    avg_rnd = {1'b0, avg_d} + {1'b0, ehpd_pkg::HalfFix};
    f_wide  = avg_rnd[Aw:Fb];
    smoothed = f_wide[Sb] ? ehpd_pkg::SampleMax : f_wide[Sb-1:0];

    if (!seat_q) begin
      seat_d = (smoothed >= thr_on_q);
    end else begin
      seat_d = !(smoothed <= thr_off_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      seat_q      <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        avg_q  <= avg_d;
        seat_q <= seat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_sample_q <= s_axis_tdata[Sb-1:0];
    end
    if (s1_fire) begin
      out_smoothed_q <= smoothed;
      out_occ_q      <= seat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ehpd_pkg::OutDataW - Sb - 1){1'b0}}, out_occ_q, out_smoothed_q};

`ifndef SYNTHESIS
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_q <= ehpd_pkg::AvgMax)
    else $error("average above full scale");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q >= ehpd_pkg::AlphaW'(ehpd_pkg::AlphaMin) &&
    alpha_q <= ehpd_pkg::AlphaW'(ehpd_pkg::AlphaMax))
    else $error("alpha outside clamp range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_valid_q && out_occ_q == seat_q))
    else $error("result missing or seat state mismatch");
`endif

endmodule

// ----- bench/tb_ema_hysteresis_presence_detector.sv -----
`timescale 1ns / 1ps

module tb_ema_hysteresis_presence_detector;
  import ehpd_pkg::*;

  localparam int StallLimit   = 4000;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 12;
  localparam int Segments     = 12;
  localparam int SegSamples   = 66;
  localparam logic [CfgIndexW-1:0] RegSpare = 2'd3;  // no register behind this index

  typedef enum {FeedSample, FeedWrite, FeedDrain, FeedIdleMix} feed_kind_e;

  typedef struct {
    feed_kind_e             kind;
    logic [SampleBits-1:0]  sample;
    logic [CfgIndexW-1:0]   index;
    logic [CfgDataW-1:0]    data;
    int                     send_pct;
    int                     recv_pct;
  } feed_entry_t;

  typedef struct packed {
    logic [SampleBits-1:0] smoothed;
    logic                  occupied;
  } seat_reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;   // [13:0] sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;      // [13:0] smoothed, [14] occupied
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  feed_entry_t   feed_q[$];
  seat_reading_t expected_readings_q[$];

  // predictor state and register copies
  longint                avg_fix;
  logic                  seat_taken;
  longint                alpha_w;
  logic [SampleBits-1:0] thr_on_w;
  logic [SampleBits-1:0] thr_off_w;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  fail_cnt = 0;
  int  stall_cycles = 0;
  int  quiet_cycles = 0;
  bit  sample_taken = 1'b0;
  bit  write_taken = 1'b0;

  // stimulus generator's view of the thresholds
  int gen_on;
  int gen_off;

  ema_hysteresis_presence_detector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic void apply_reg_write(input logic [CfgIndexW-1:0] idx,
                                          input logic [CfgDataW-1:0] val);
    case (cfg_reg_e'(idx))
      RegAlpha: begin
        if (val < AlphaMin) alpha_w = AlphaMin;
        else if (val > AlphaMax) alpha_w = AlphaMax;
        else alpha_w = longint'(val);
      end
      RegThrOn:  thr_on_w = val[SampleBits-1:0];
      RegThrOff: thr_off_w = val[SampleBits-1:0];
      default: ;
    endcase
  endfunction

  function automatic seat_reading_t ema_step(input logic [SampleBits-1:0] s);
    longint target;
    longint t;
    longint rounded;
    seat_reading_t r;
    target = longint'(s) << AlphaFracBits;
    if (avg_fix <= StartLimit) begin
      avg_fix = target;
    end else begin
      // arithmetic shift floors, which gives round half up on the quotient
      t = alpha_w * (target - avg_fix) + (longint'(1) << (AlphaFracBits - 1));
      avg_fix = avg_fix + (t >>> AlphaFracBits);
    end
    if (avg_fix < 0) avg_fix = 0;
    if (avg_fix > longint'(AvgMax)) avg_fix = longint'(AvgMax);
    rounded = (avg_fix + (longint'(1) << (AlphaFracBits - 1))) >>> AlphaFracBits;
    if (rounded > longint'(SampleMax)) rounded = longint'(SampleMax);
    r.smoothed = rounded[SampleBits-1:0];
    if (!seat_taken) begin
      if (r.smoothed >= thr_on_w) seat_taken = 1'b1;
    end else begin
      if (r.smoothed <= thr_off_w) seat_taken = 1'b0;
    end
    r.occupied = seat_taken;
    return r;
  endfunction

  task automatic push_sample(input int s);
    feed_entry_t e;
    e = '{kind: FeedSample, sample: SampleBits'(s), index: '0, data: '0,
          send_pct: 0, recv_pct: 0};
    feed_q.push_back(e);
  endtask

  task automatic push_write(input logic [CfgIndexW-1:0] idx, input int val);
    feed_entry_t e;
    e = '{kind: FeedWrite, sample: '0, index: idx, data: CfgDataW'(val),
          send_pct: 0, recv_pct: 0};
    feed_q.push_back(e);
  endtask

  task automatic push_idle_mix(input int send_pct, input int recv_pct);
    feed_entry_t e;
    e = '{kind: FeedIdleMix, sample: '0, index: '0, data: '0,
          send_pct: send_pct, recv_pct: recv_pct};
    feed_q.push_back(e);
  endtask

  task automatic push_drain();
    feed_entry_t e;
    e = '{kind: FeedDrain, sample: '0, index: '0, data: '0, send_pct: 0, recv_pct: 0};
    feed_q.push_back(e);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    feed_entry_t          head;
    logic                 nv;
    logic                 cv;
    logic                 hold;
    logic [InDataW-1:0]   nd;
    logic [CfgIndexW-1:0] ci;
    logic [CfgDataW-1:0]  cd;
    nv = s_axis_tvalid;
    cv = cfg_valid_i;
    nd = s_axis_tdata;
    ci = cfg_index_i;
    cd = cfg_data_i;
    hold = 1'b0;
    if (rst_ni) begin
      if (nv && sample_taken) nv = 1'b0;
      if (cv && write_taken) cv = 1'b0;
      while (!nv && !cv && !hold && feed_q.size() != 0) begin
        head = feed_q[0];
        case (head.kind)
          FeedIdleMix: begin
            send_idle_pct = head.send_pct;
            recv_idle_pct = head.recv_pct;
            void'(feed_q.pop_front());
          end
          FeedDrain: begin
            if (quiet_cycles >= SettleCycles) void'(feed_q.pop_front());
            else hold = 1'b1;
          end
          FeedWrite: begin
            // registers change only with the pipeline empty
            if (quiet_cycles >= SettleCycles) begin
              cv = 1'b1;
              ci = head.index;
              cd = head.data;
              void'(feed_q.pop_front());
            end else begin
              hold = 1'b1;
            end
          end
          default: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              nv = 1'b1;
              nd = InDataW'(head.sample);
              void'(feed_q.pop_front());
            end else begin
              hold = 1'b1;
            end
          end
        endcase
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
    cfg_valid_i <= cv;
    cfg_index_i <= ci;
    cfg_data_i <= cd;
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk_i) begin
    seat_reading_t want;
    seat_reading_t got;
    bit result_taken;
    if (rst_ni) begin
      sample_taken = s_axis_tvalid && s_axis_tready;
      write_taken = cfg_valid_i && cfg_ready_o;
      result_taken = m_axis_tvalid && m_axis_tready;
      if (write_taken) apply_reg_write(cfg_index_i, cfg_data_i);
      if (sample_taken) expected_readings_q.push_back(ema_step(s_axis_tdata[SampleBits-1:0]));
      if (result_taken) begin
        got.smoothed = m_axis_tdata[SampleBits-1:0];
        got.occupied = m_axis_tdata[SampleBits];
        if (expected_readings_q.size() == 0) begin
          $error("unexpected transaction on m_axis: smoothed %0d occupied %0d",
                 got.smoothed, got.occupied);
          fail_cnt++;
        end else begin
          want = expected_readings_q.pop_front();
          if (got.smoothed !== want.smoothed) begin
            $error("smoothed mismatch: expected %0d, got %0d", want.smoothed, got.smoothed);
            fail_cnt++;
          end
          if (got.occupied !== want.occupied) begin
            $error("occupied mismatch: expected %0d, got %0d", want.occupied, got.occupied);
            fail_cnt++;
          end
        end
      end
      if (expected_readings_q.size() == 0 && !sample_taken) quiet_cycles++;
      else quiet_cycles = 0;
      if (sample_taken || write_taken || result_taken) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int lvl;
    int run_left;
    int s;
    int alpha_raw;
    avg_fix = 0;
    seat_taken = 1'b0;
    alpha_w = AlphaReset;
    thr_on_w = SampleMax;
    thr_off_w = '0;
    run_left = 0;
    lvl = 0;

    // directed part, starting from the reset register values
    push_idle_mix(15, 87);
    push_sample(0);       // zero at start loads zero, next one loads again
    push_sample(0);
    push_sample(16383);   // loaded directly, reaches threshold_on
    push_sample(16383);
    push_sample(0);
    push_sample(0);
    push_sample(1);
    push_write(RegAlpha, 0);          // clamps to the minimum
    push_write(RegAlpha, 16'hFFFF);   // clamps to 1.0
    push_write(RegThrOn, 16'hFFFF);   // upper bits dropped
    push_write(RegThrOff, 16'hC064);  // 100 after masking
    push_write(RegSpare, 16'hFFFF);
    push_sample(16383);
    push_sample(101);
    push_sample(100);     // at threshold_off, seat empties
    push_sample(16382);
    push_sample(16383);
    push_sample(14'h2AAA);
    push_sample(14'h1555);
    // overlapping thresholds
    push_write(RegThrOn, 50);
    push_write(RegThrOff, 200);
    push_sample(0);
    push_sample(60);
    push_sample(150);
    push_sample(150);
    push_sample(250);
    push_write(RegAlpha, 327);
    push_sample(16383);
    push_sample(0);
    push_sample(8191);
    push_drain();

    // random part: level runs (zero, full scale, the thresholds or random) with jitter, plus noise
    for (int seg = 0; seg < Segments; seg++) begin
      if (seg == 4) push_idle_mix(87, 15);
      if (seg == 8) push_idle_mix(0, 0);
      case ($urandom_range(5))
        0:       alpha_raw = $urandom_range(AlphaMin - 1);
        1:       alpha_raw = $urandom_range(65535, AlphaMax + 1);
        2:       alpha_raw = AlphaMin;
        3:       alpha_raw = AlphaMax;
        default: alpha_raw = $urandom_range(AlphaMax - 1, 2000);
      endcase
      if (seg == 2) begin
        gen_on = 0;
        gen_off = 16383;
      end else if (seg == 5) begin
        gen_on = 16383;
        gen_off = 0;
      end else begin
        gen_on = $urandom_range(16383);
        gen_off = $urandom_range(gen_on);
      end
      push_write(RegAlpha, alpha_raw);
      push_write(RegThrOn, ($urandom_range(3) << SampleBits) | gen_on);
      push_write(RegThrOff, ($urandom_range(3) << SampleBits) | gen_off);
      if ($urandom_range(2) == 0) push_write(RegSpare, $urandom_range(65535));
      for (int k = 0; k < SegSamples; k++) begin
        if (k == SegSamples / 2 && seg % 3 == 1) push_drain();
        if (run_left == 0) begin
          case ($urandom_range(4))
            0:       lvl = 0;
            1:       lvl = 16383;
            2:       lvl = gen_on;
            3:       lvl = gen_off;
            default: lvl = $urandom_range(16383);
          endcase
          run_left = $urandom_range(30, 4);
        end
        run_left--;
        case ($urandom_range(9))
          0:       s = $urandom_range(16383);
          1:       s = 0;
          default: s = lvl + int'($urandom_range(64)) - 32;
        endcase
        if (s < 0) s = 0;
        if (s > 16383) s = 16383;
        push_sample(s);
      end
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || s_axis_tvalid || cfg_valid_i ||
           expected_readings_q.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0 && expected_readings_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ehpd_pkg.sv
rtl/ema_hysteresis_presence_detector.sv
bench/tb_ema_hysteresis_presence_detector.sv
